### hdl/spf_pkg.sv
package spf_pkg;

    localparam int unsigned DEF_TABLE_ENTRIES = 16;
    localparam int unsigned DEF_QUEUE_DEPTH   = 20;
    localparam int unsigned DEF_TAG_SHIFT     = 15;

    localparam logic [15:0] RST_NEXT_LINE_OFFSET = 16'd16;
    localparam logic [15:0] RST_INITIAL_STRIDE   = 16'd4;

    // register index (paddr bit 2)
    localparam logic REG_NEXT_LINE_OFFSET = 1'b0;
    localparam logic REG_INITIAL_STRIDE   = 1'b1;

    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    localparam logic [1:0] MODE_INIT      = 2'd0;
    localparam logic [1:0] MODE_TRANSIENT = 2'd1;
    localparam logic [1:0] MODE_STEADY    = 2'd2;
    localparam logic [1:0] MODE_NOPRED    = 2'd3;

    typedef struct packed {
        logic        func;
        logic [31:0] access_addr;
    } t_in_word;

    typedef struct packed {
        logic        prefetch_valid;
        logic [31:0] prefetch_addr;
        logic [4:0]  queue_count;
    } t_out_word;

    typedef struct packed {
        logic pop;
        logic push;
    } t_q_ctl;

endpackage

### hdl/spf_queue.sv
module spf_queue #(
    parameter int unsigned QUEUE_DEPTH = spf_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    parameter int unsigned FW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spf_pkg::t_q_ctl    i_ctl,
    input  logic [FW-1:0]      i_k,
    input  logic [31:0]        i_wdata,
    output logic [31:0]        o_rdata,
    output logic [FW-1:0]      o_fill
);
    import spf_pkg::*;

    logic [31:0]   r_store [QUEUE_DEPTH];
    logic [QW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [FW:0]   sum;
    logic [FW:0]   wrapped;
    logic [QW-1:0] idx;

    // slot at head+k, one conditional subtract since k <= depth
    always_comb begin
        sum     = (FW+1)'(r_head) + (FW+1)'(i_k);
        wrapped = (sum >= (FW+1)'(QUEUE_DEPTH)) ? sum - (FW+1)'(QUEUE_DEPTH) : sum;
        idx     = QW'(wrapped);
    end

    assign o_rdata = r_store[idx];
    assign o_fill  = r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_ctl.pop) begin
            r_head <= (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            r_fill <= r_fill - 1'b1;
        end else if (i_ctl.push) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_store[idx] <= i_wdata;
        end
    end

endmodule

### hdl/stride_prefetcher_rpt_core.sv
// channel | valid      | stall       | word
// in      | i_in_valid | o_in_stall  | i_in_word  (func, access_addr)
// out     | o_out_valid| i_out_stall | o_out_word (prefetch_valid, prefetch_addr, queue_count)
// cfg     | APB psel/penable/pwrite, paddr[2] selects register, pready tied high
// A pop reads the queue head, then finishes. An access scans every table entry with one
// shared tag compare, then allocates an entry on a miss or visits each entry in turn on a
// hit, plus for each queued prefetch a duplicate scan of the occupied queue slots through
// the single queue compare (it stops at the first match), then a finish step. Input is
// stalled while a word is in work, including while the finish waits on a held output word.
// Synchronous active-low reset clears table valid bits, pointers and the queue.
module stride_prefetcher_rpt_core #(
    parameter int unsigned TABLE_ENTRIES = spf_pkg::DEF_TABLE_ENTRIES,
    parameter int unsigned QUEUE_DEPTH   = spf_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned TAG_SHIFT     = spf_pkg::DEF_TAG_SHIFT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spf_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spf_pkg::t_out_word o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import spf_pkg::*;

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned TW = 32 - TAG_SHIFT;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_MISS = 6'b000100,
        S_UPD  = 6'b001000,
        S_DUP  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;

    logic [15:0] r_nlo;
    logic [15:0] r_istride;

    logic              r_valid  [TABLE_ENTRIES];
    logic [TW-1:0]     r_tag    [TABLE_ENTRIES];
    logic [31:0]       r_last   [TABLE_ENTRIES];
    logic [31:0]       r_stride [TABLE_ENTRIES];
    logic [1:0]        r_mode   [TABLE_ENTRIES];

    logic [IW-1:0]            r_ap;
    logic [IW-1:0]            r_e;
    logic [TABLE_ENTRIES-1:0] r_hit;
    logic                     r_any;
    logic                     r_miss;
    logic [31:0]              r_addr;
    logic [31:0]              r_paddr;
    logic [FW-1:0]            r_k;
    logic                     r_pv;
    logic [31:0]              r_pa;
    logic                     r_ov;
    t_out_word                r_out;

    t_q_ctl        q_ctl;
    logic [31:0]   q_rdata;
    logic [FW-1:0] q_fill;

    logic [TW-1:0] cur_tag;
    logic          hit_e;
    logic [31:0]   delta;
    logic [31:0]   addr_nl;
    logic          e_last;
    logic          out_free;
    logic          dup_end;
    logic          in_acc;

    // table write controls
    logic          alloc_en;
    logic [31:0]   alloc_stride;
    logic          upd_last_en;
    logic          upd_stride_en;
    logic          upd_mode_en;
    logic [1:0]    upd_mode;
    logic          push_req;
    logic [31:0]   push_addr;

    assign cur_tag  = r_addr[31:TAG_SHIFT];
    assign hit_e    = r_valid[r_e] && (r_tag[r_e] == cur_tag);
    assign delta    = r_addr - r_last[r_e];
    assign addr_nl  = r_addr + {16'b0, r_nlo};
    assign e_last   = (r_e == IW'(TABLE_ENTRIES - 1));
    assign out_free = !r_ov || !i_out_stall;
    assign in_acc   = i_in_valid && !o_in_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_INITIAL_STRIDE) ? {16'b0, r_istride}
                                                          : {16'b0, r_nlo};

    // duplicate scan ends on a match or after the last occupied slot
    assign dup_end = (r_k == q_fill) || (q_rdata == r_paddr);

    always_comb begin
        alloc_en      = 1'b0;
        alloc_stride  = {16'b0, r_istride};
        upd_last_en   = 1'b0;
        upd_stride_en = 1'b0;
        upd_mode_en   = 1'b0;
        upd_mode      = MODE_NOPRED;
        push_req      = 1'b0;
        push_addr     = addr_nl;
        case (r_state)
            S_MISS: begin
                alloc_en = 1'b1;
                push_req = 1'b1;
            end
            S_UPD: begin
                if (r_hit[r_e]) begin
                    if (r_mode[r_e] == MODE_INIT) begin
                        upd_last_en   = 1'b1;
                        upd_stride_en = 1'b1;
                        upd_mode_en   = 1'b1;
                        upd_mode      = MODE_TRANSIENT;
                    end else if (delta == r_stride[r_e]) begin
                        upd_last_en = 1'b1;
                        upd_mode_en = 1'b1;
                        push_req    = 1'b1;
                        if (r_mode[r_e] == MODE_NOPRED) begin
                            upd_mode = MODE_TRANSIENT;
                        end else begin
                            upd_mode  = MODE_STEADY;
                            push_addr = r_addr + r_stride[r_e];
                        end
                    end else begin
                        push_req    = 1'b1;
                        upd_mode_en = 1'b1;
                        upd_mode    = MODE_NOPRED;
                        if (r_mode[r_e] == MODE_STEADY || r_mode[r_e] == MODE_NOPRED) begin
                            alloc_en     = 1'b1;
                            alloc_stride = delta;
                        end else begin
                            upd_last_en   = 1'b1;
                            upd_stride_en = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        q_ctl.pop  = (r_state == S_IDLE) && in_acc && (i_in_word.func == FUNC_POP)
                     && (q_fill != '0);
        q_ctl.push = (r_state == S_DUP) && (r_k == q_fill)
                     && (q_fill < FW'(QUEUE_DEPTH));
    end

    spf_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QW          (QW),
        .FW          (FW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_k     (r_k),
        .i_wdata (r_paddr),
        .o_rdata (q_rdata),
        .o_fill  (q_fill)
    );

    // table payload; an alloc onto the entry being updated keeps the update's mode
    always_ff @(posedge i_clk) begin
        if (alloc_en) begin
            r_tag[r_ap]    <= cur_tag;
            r_last[r_ap]   <= r_addr;
            r_stride[r_ap] <= alloc_stride;
            if (!(upd_mode_en && (r_ap == r_e))) begin
                r_mode[r_ap] <= MODE_INIT;
            end
        end
        if (upd_last_en) begin
            r_last[r_e] <= r_addr;
        end
        if (upd_stride_en) begin
            r_stride[r_e] <= delta;
        end
        if (upd_mode_en) begin
            r_mode[r_e] <= upd_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_nlo     <= RST_NEXT_LINE_OFFSET;
            r_istride <= RST_INITIAL_STRIDE;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_ap   <= '0;
            r_e    <= '0;
            r_hit  <= '0;
            r_any  <= 1'b0;
            r_miss <= 1'b0;
            r_k    <= '0;
            r_pv   <= 1'b0;
            r_pa   <= '0;
            r_ov   <= 1'b0;
            r_out  <= '0;
            r_addr <= '0;
            r_paddr <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_NEXT_LINE_OFFSET) begin
                    r_nlo <= pwdata[15:0];
                end else begin
                    r_istride <= pwdata[15:0];
                end
            end
            if (alloc_en) begin
                r_valid[r_ap] <= 1'b1;
                r_ap <= (r_ap == IW'(TABLE_ENTRIES - 1)) ? '0 : r_ap + 1'b1;
            end
            if (r_ov && !i_out_stall && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            if (push_req) begin
                r_paddr <= push_addr;
                r_k     <= '0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_addr <= i_in_word.access_addr;
                        r_e    <= '0;
                        r_any  <= 1'b0;
                        r_miss <= 1'b0;
                        r_pv   <= 1'b0;
                        r_pa   <= '0;
                        if (i_in_word.func == FUNC_POP) begin
                            if (q_fill != '0) begin
                                r_pv <= 1'b1;
                                r_pa <= q_rdata;
                            end
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_hit[r_e] <= hit_e;
                    if (e_last) begin
                        r_e     <= '0;
                        r_state <= (r_any || hit_e) ? S_UPD : S_MISS;
                    end else begin
                        r_any <= r_any || hit_e;
                        r_e   <= r_e + 1'b1;
                    end
                end
                S_MISS: begin
                    r_miss  <= 1'b1;
                    r_state <= S_DUP;
                end
                S_UPD: begin
                    if (push_req) begin
                        r_state <= S_DUP;
                    end else if (e_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_e <= r_e + 1'b1;
                    end
                end
                S_DUP: begin
                    if (dup_end) begin
                        r_k <= '0;
                        if (r_miss || e_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_e     <= r_e + 1'b1;
                            r_state <= S_UPD;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.prefetch_valid <= r_pv;
                        r_out.prefetch_addr  <= r_pa;
                        r_out.queue_count    <= 5'(q_fill);
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_fill <= FW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while busy");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.func == FUNC_POP && q_fill != '0)
        |=> (q_fill == $past(q_fill) - 1'b1))
        else $error("pop did not drain queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_ctl.push |-> (q_fill != FW'(QUEUE_DEPTH)))
        else $error("push into full queue");

endmodule
